// File: rtl/core/cau_pkg.sv
// Shared types, codes and saturation helpers for the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

    localparam int FRAC_BITS_DEF = 8;

    // Quotient bits resolved by the divider; a quotient at or above 2^Q_BITS is saturated.
    localparam int Q_BITS = 17;

    // Width of a rounded magnitude before saturation.
    localparam int MAG_W = 34;

    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(32767);
    localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(32768);
    localparam logic [15:0] SAT_POS = 16'h7FFF;
    localparam logic [15:0] SAT_NEG = 16'h8000;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // Control and finished results that travel alongside the divider.
    typedef struct packed {
        logic        valid;
        logic        is_div;
        logic        dz;
        logic        neg_re;
        logic        neg_im;
        logic        ovf;
        logic [15:0] re;
        logic [15:0] im;
    } side_t;

    // Saturate a sign and magnitude to 16 bits; the top bit of the result is the overflow flag.
    function automatic logic [16:0] sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
        logic [16:0] r;
        if (!neg) begin
            if (mag > POS_LIMIT) begin
                r = {1'b1, SAT_POS};
            end else begin
                r = {1'b0, mag[15:0]};
            end
        end else begin
            if (mag > NEG_LIMIT) begin
                r = {1'b1, SAT_NEG};
            end else begin
                r = {1'b0, (~mag[15:0]) + 16'd1};
            end
        end
        return r;
    endfunction

    // Saturate a 17-bit two's complement value to 16 bits, with the flag on top.
    function automatic logic [16:0] sat17(input logic [16:0] v);
        logic [16:0] r;
        if (v[16] != v[15]) begin
            r = {1'b1, (v[16] ? SAT_NEG : SAT_POS)};
        end else begin
            r = {1'b0, v[15:0]};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: pipeline control and result register.
`timescale 1ns / 1ps

// The unit takes one request per cycle while req_stall is low and returns one result
// per request, in order. The result passes through 22 register stages. Every operation
// goes through the same pipeline: one stage of 16x16 multipliers and add/subtract
// sums, one stage that combines the product terms and saturates the sums, one stage
// that rounds and saturates multiply and forms the divider operands, a range check,
// seventeen restoring divider stages that each resolve one quotient bit, and the
// result register. The pipeline moves as a whole; when a result waits with res_stall
// high the whole pipeline holds and req_stall rises, and empty slots still move
// forward whenever the result register is free. Division rounds to nearest with ties
// away from zero; a zero divisor gives a zero result with divide_by_zero set, and any
// saturated part sets overflow.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         operation,
    input  logic signed [15:0] a_real,
    input  logic signed [15:0] a_imag,
    input  logic signed [15:0] b_real,
    input  logic signed [15:0] b_imag,
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [15:0] result_real,
    output logic signed [15:0] result_imag,
    output logic               overflow,
    output logic               divide_by_zero
);

    localparam int QB = cau_pkg::Q_BITS;
    localparam int NW = FRAC_BITS + 35;

    // The pipeline advances whenever the result register is empty or being taken.
    logic adv;
    assign adv       = !res_valid || !res_stall;
    assign req_stall = !adv;

    cau_pkg::side_t fr_side, dv_side;
    logic [NW-1:0]  n_re, n_im;
    logic [32:0]    d_val;
    logic [QB-1:0]  q_re, q_im;
    logic           big_re, big_im;

    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (req_valid),
        .operation (operation),
        .a_real    (a_real),
        .a_imag    (a_imag),
        .b_real    (b_real),
        .b_imag    (b_imag),
        .side_out  (fr_side),
        .n_re      (n_re),
        .n_im      (n_im),
        .d_out     (d_val)
    );

    cau_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .side_in  (fr_side),
        .n_re     (n_re),
        .n_im     (n_im),
        .d_in     (d_val),
        .side_out (dv_side),
        .q_re     (q_re),
        .q_im     (q_im),
        .big_re   (big_re),
        .big_im   (big_im)
    );

    // Final selection: quotients are saturated here, everything else is already done.
    logic [cau_pkg::MAG_W-1:0] mq_re, mq_im;
    logic [16:0]               div_re, div_im;
    logic [15:0]               re_next, im_next;
    logic                      ovf_next, dz_next;

    always_comb
    begin
        mq_re  = big_re ? {cau_pkg::MAG_W{1'b1}} : cau_pkg::MAG_W'(q_re);
        mq_im  = big_im ? {cau_pkg::MAG_W{1'b1}} : cau_pkg::MAG_W'(q_im);
        div_re = cau_pkg::sat_mag(dv_side.neg_re, mq_re);
        div_im = cau_pkg::sat_mag(dv_side.neg_im, mq_im);
        if (!dv_side.is_div) begin
            re_next  = dv_side.re;
            im_next  = dv_side.im;
            ovf_next = dv_side.ovf;
            dz_next  = 1'b0;
        end else if (dv_side.dz) begin
            re_next  = 16'd0;
            im_next  = 16'd0;
            ovf_next = 1'b0;
            dz_next  = 1'b1;
        end else begin
            re_next  = div_re[15:0];
            im_next  = div_im[15:0];
            ovf_next = div_re[16] | div_im[16];
            dz_next  = 1'b0;
        end
    end

    logic        res_valid_reg;
    logic [15:0] re_reg, im_reg;
    logic        ovf_reg, dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (adv) begin
            res_valid_reg <= dv_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            ovf_reg <= ovf_next;
            dz_reg  <= dz_next;
        end
    end

    assign res_valid      = res_valid_reg;
    assign result_real    = re_reg;
    assign result_imag    = im_reg;
    assign overflow       = ovf_reg;
    assign divide_by_zero = dz_reg;

    // A zero divisor always yields a clean zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && divide_by_zero |-> result_real == 16'sd0 && result_imag == 16'sd0
            && !overflow)
        else $error("divide by zero result is not zero");

    // Overflow means at least one part sits at a saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && overflow |-> result_real == 16'sh7FFF || result_real == 16'sh8000
            || result_imag == 16'sh7FFF || result_imag == 16'sh8000)
        else $error("overflow without a saturated part");

    // Requests are held back only while a finished result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> res_valid && res_stall)
        else $error("request stalled with the result side free");

    // A waiting result holds its value across a stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(result_real) && $stable(result_imag))
        else $error("stalled result changed");

endmodule

// File: rtl/core/cau_front.sv
// Front pipeline: products and sums, saturated add/sub, rounded multiply, divider operands.
`timescale 1ns / 1ps

module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [1:0]               operation,
    input  logic signed [15:0]       a_real,
    input  logic signed [15:0]       a_imag,
    input  logic signed [15:0]       b_real,
    input  logic signed [15:0]       b_imag,
    output cau_pkg::side_t           side_out,
    output logic [FRAC_BITS+34:0]    n_re,
    output logic [FRAC_BITS+34:0]    n_im,
    output logic [32:0]              d_out
);

    localparam int NW = FRAC_BITS + 35;
    localparam int RW = cau_pkg::MAG_W + 1;

    // Stage 1: raw products and the add/subtract sums.
    logic        v1_reg;
    logic [1:0]  op1_reg;
    logic [31:0] ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    logic [16:0] sre_reg, sim_reg;

    // Stage 2: combined product terms and saturated sums.
    logic        v2_reg;
    logic [1:0]  op2_reg;
    logic [32:0] mre_reg, mim_reg, dre_reg, dim_reg;
    logic [31:0] den_reg;
    logic [16:0] are_reg, aim_reg;

    // Stage 3 registers.
    cau_pkg::side_t side_reg;
    logic [NW-1:0]  nre_reg, nim_reg;
    logic [32:0]    d_reg;

    logic [16:0] sre_next, sim_next;

    always_comb
    begin
        if (operation == cau_pkg::OP_SUB) begin
            sre_next = {a_real[15], a_real} - {b_real[15], b_real};
            sim_next = {a_imag[15], a_imag} - {b_imag[15], b_imag};
        end else begin
            sre_next = {a_real[15], a_real} + {b_real[15], b_real};
            sim_next = {a_imag[15], a_imag} + {b_imag[15], b_imag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            op1_reg <= operation;
            ac_reg  <= a_real * b_real;
            bd_reg  <= a_imag * b_imag;
            ad_reg  <= a_real * b_imag;
            bc_reg  <= a_imag * b_real;
            cc_reg  <= b_real * b_real;
            dd_reg  <= b_imag * b_imag;
            sre_reg <= sre_next;
            sim_reg <= sim_next;

            op2_reg <= op1_reg;
            mre_reg <= {ac_reg[31], ac_reg} - {bd_reg[31], bd_reg};
            mim_reg <= {ad_reg[31], ad_reg} + {bc_reg[31], bc_reg};
            dre_reg <= {ac_reg[31], ac_reg} + {bd_reg[31], bd_reg};
            dim_reg <= {bc_reg[31], bc_reg} - {ad_reg[31], ad_reg};
            den_reg <= cc_reg + dd_reg;
            are_reg <= cau_pkg::sat17(sre_reg);
            aim_reg <= cau_pkg::sat17(sim_reg);
        end
    end

    // Stage 3: magnitudes, multiply rounding and divider numerators.
    logic [32:0]                mag_mre, mag_mim, mag_dre, mag_dim;
    logic [RW-1:0]              rnd_re, rnd_im;
    logic [cau_pkg::MAG_W-1:0]  qm_re, qm_im;
    logic [16:0]                mul_re, mul_im;
    cau_pkg::side_t             side_next;

    always_comb
    begin
        mag_mre = mre_reg[32] ? (~mre_reg) + 33'd1 : mre_reg;
        mag_mim = mim_reg[32] ? (~mim_reg) + 33'd1 : mim_reg;
        mag_dre = dre_reg[32] ? (~dre_reg) + 33'd1 : dre_reg;
        mag_dim = dim_reg[32] ? (~dim_reg) + 33'd1 : dim_reg;

        // Round half away from zero: (2|x| + 2^F) >> (F+1).
        rnd_re = (RW'(mag_mre) << 1) + (RW'(1) << FRAC_BITS);
        rnd_im = (RW'(mag_mim) << 1) + (RW'(1) << FRAC_BITS);
        qm_re  = cau_pkg::MAG_W'(rnd_re >> (FRAC_BITS + 1));
        qm_im  = cau_pkg::MAG_W'(rnd_im >> (FRAC_BITS + 1));
        mul_re = cau_pkg::sat_mag(mre_reg[32], qm_re);
        mul_im = cau_pkg::sat_mag(mim_reg[32], qm_im);

        side_next        = '0;
        side_next.valid  = v2_reg;
        side_next.is_div = (op2_reg == cau_pkg::OP_DIV);
        side_next.dz     = (op2_reg == cau_pkg::OP_DIV) && (den_reg == 32'd0);
        side_next.neg_re = dre_reg[32];
        side_next.neg_im = dim_reg[32];
        case (op2_reg)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB:
            begin
                side_next.re  = are_reg[15:0];
                side_next.im  = aim_reg[15:0];
                side_next.ovf = are_reg[16] | aim_reg[16];
            end
            cau_pkg::OP_MUL:
            begin
                side_next.re  = mul_re[15:0];
                side_next.im  = mul_im[15:0];
                side_next.ovf = mul_re[16] | mul_im[16];
            end
            default:
            begin
                side_next.re  = 16'd0;
                side_next.im  = 16'd0;
                side_next.ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            side_reg <= '0;
        end else if (adv) begin
            side_reg <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            // Quotient numerators are 2|x|*2^F + den against a divisor of 2*den.
            nre_reg <= NW'({mag_dre, {(FRAC_BITS + 1){1'b0}}}) + NW'(den_reg);
            nim_reg <= NW'({mag_dim, {(FRAC_BITS + 1){1'b0}}}) + NW'(den_reg);
            d_reg   <= {den_reg, 1'b0};
        end
    end

    assign side_out = side_reg;
    assign n_re     = nre_reg;
    assign n_im     = nim_reg;
    assign d_out    = d_reg;

endmodule

// File: rtl/core/cau_div.sv
// Pipelined restoring divider, one quotient bit per stage, for both result parts.
`timescale 1ns / 1ps

module cau_div #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  cau_pkg::side_t               side_in,
    input  logic [FRAC_BITS+34:0]        n_re,
    input  logic [FRAC_BITS+34:0]        n_im,
    input  logic [32:0]                  d_in,
    output cau_pkg::side_t               side_out,
    output logic [cau_pkg::Q_BITS-1:0]   q_re,
    output logic [cau_pkg::Q_BITS-1:0]   q_im,
    output logic                         big_re,
    output logic                         big_im
);

    localparam int QB = cau_pkg::Q_BITS;
    localparam int NW = FRAC_BITS + 35;
    localparam int CW = (NW > 33 + QB) ? NW : 33 + QB;

    cau_pkg::side_t  side_reg [0:QB];
    logic [CW-1:0]   rre_reg  [0:QB-1];
    logic [CW-1:0]   rim_reg  [0:QB-1];
    logic [32:0]     d_reg    [0:QB-1];
    logic [QB-1:0]   qre_reg  [0:QB];
    logic [QB-1:0]   qim_reg  [0:QB];
    logic            bre_reg  [0:QB];
    logic            bim_reg  [0:QB];

    logic [CW-1:0] dtop;
    assign dtop = CW'(d_in) << QB;

    // Range stage: a quotient of 2^QB or more can only saturate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            side_reg[0] <= '0;
        end else if (adv) begin
            side_reg[0] <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            rre_reg[0] <= CW'(n_re);
            rim_reg[0] <= CW'(n_im);
            d_reg[0]   <= d_in;
            qre_reg[0] <= '0;
            qim_reg[0] <= '0;
            bre_reg[0] <= CW'(n_re) >= dtop;
            bim_reg[0] <= CW'(n_im) >= dtop;
        end
    end

    for (genvar g = 1; g <= QB; g++) begin : g_step
        localparam int J = QB - g;

        logic [CW-1:0] dsh;
        logic          ge_re, ge_im;
        logic [QB-1:0] qre_next, qim_next;

        always_comb
        begin
            dsh      = CW'(d_reg[g-1]) << J;
            ge_re    = rre_reg[g-1] >= dsh;
            ge_im    = rim_reg[g-1] >= dsh;
            qre_next = qre_reg[g-1];
            qim_next = qim_reg[g-1];
            qre_next[J] = ge_re;
            qim_next[J] = ge_im;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                side_reg[g] <= '0;
            end else if (adv) begin
                side_reg[g] <= side_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv) begin
                qre_reg[g] <= qre_next;
                qim_reg[g] <= qim_next;
                bre_reg[g] <= bre_reg[g-1];
                bim_reg[g] <= bim_reg[g-1];
            end
        end

        if (g < QB) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv) begin
                    rre_reg[g] <= ge_re ? rre_reg[g-1] - dsh : rre_reg[g-1];
                    rim_reg[g] <= ge_im ? rim_reg[g-1] - dsh : rim_reg[g-1];
                    d_reg[g]   <= d_reg[g-1];
                end
            end
        end
    end

    assign side_out = side_reg[QB];
    assign q_re     = qre_reg[QB];
    assign q_im     = qim_reg[QB];
    assign big_re   = bre_reg[QB];
    assign big_im   = bim_reg[QB];

endmodule
